// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the deque design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock, disabled while the reset is active.
`define CDQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clock and reset names.
`define CDQ_ASSERT(label, prop, msg) \
  `CDQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/cdq_pkg.sv =====
// ---------------------------------------------------------------------------
// cdq_pkg
// Types, codes and constants shared by the circular deque modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int WordW    = 32;
  localparam int OpW      = 3;
  localparam int StatW    = 2;
  localparam int DefDepth = 16;

  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpW-1:0] OP_READ_ALL   = 3'd4;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ADDR_FRONT,
    ADDR_FRONT_DN,
    ADDR_BACK,
    ADDR_BACK_DN,
    ADDR_SCAN_UP
  } addr_sel_e;

  typedef struct packed {
    logic             mem_we;
    logic             mem_re;
    addr_sel_e        addr_sel;
    logic             front_up;
    logic             front_dn;
    logic             back_up;
    logic             back_dn;
    logic             scan_load;
    logic             scan_up;
    logic             out_ld_const;
    logic             out_word_ones;
    logic [StatW-1:0] out_status;
    logic             out_ld_mem;
    logic             last_from_scan;
  } cdq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_last;
  } cdq_sts_t;

endpackage

// ===== design/cdq_ram.sv =====
// ---------------------------------------------------------------------------
// cdq_ram
// Generic single-port RAM with one address and a registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cdq_dp.sv =====
// ---------------------------------------------------------------------------
// cdq_dp
// Datapath: front, back and scan pointers, the ring memory and the
// output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_dp import cdq_pkg::*; #(
  parameter int DEPTH = DefDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cdq_cmd_t                cmd_i,
  input  logic signed [WordW-1:0] value_i,
  output cdq_sts_t                sts_o,
  output logic signed [WordW-1:0] word_o,
  output logic [StatW-1:0]        status_o,
  output logic                    last_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);

  function automatic logic [PtrW-1:0] step_up(input logic [PtrW-1:0] p);
    return (p == PtrMax) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] step_dn(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrMax : p - 1'b1;
  endfunction

  logic [PtrW-1:0] front_q, front_d;
  logic [PtrW-1:0] back_q, back_d;
  logic [PtrW-1:0] scan_q, scan_d;
  logic [PtrW-1:0] front_dn, back_dn, back_up, scan_nx;
  logic [PtrW-1:0] addr;
  logic [WordW-1:0] rdata;
  logic signed [WordW-1:0] word_q, word_d;
  logic [StatW-1:0] status_q, status_d;
  logic last_q, last_d;

  assign front_dn = step_dn(front_q);
  assign back_dn  = step_dn(back_q);
  assign back_up  = step_up(back_q);
  assign scan_nx  = step_up(scan_q);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_FRONT:    addr = front_q;
      ADDR_FRONT_DN: addr = front_dn;
      ADDR_BACK:     addr = back_q;
      ADDR_BACK_DN:  addr = back_dn;
      ADDR_SCAN_UP:  addr = scan_nx;
      default:       addr = front_q;
    endcase
  end

  cdq_ram #(
    .Width(WordW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .re_i   (cmd_i.mem_re),
    .addr_i (addr),
    .wdata_i(value_i),
    .rdata_o(rdata)
  );

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    scan_d  = scan_q;
    if (cmd_i.front_up) begin
      front_d = step_up(front_q);
    end else if (cmd_i.front_dn) begin
      front_d = front_dn;
    end
    if (cmd_i.back_up) begin
      back_d = back_up;
    end else if (cmd_i.back_dn) begin
      back_d = back_dn;
    end
    if (cmd_i.scan_load) begin
      scan_d = front_q;
    end else if (cmd_i.scan_up) begin
      scan_d = scan_nx;
    end
  end

  always_comb begin
    word_d   = word_q;
    status_d = status_q;
    last_d   = last_q;
    if (cmd_i.out_ld_const) begin
      word_d   = cmd_i.out_word_ones ? {WordW{1'b1}} : '0;
      status_d = cmd_i.out_status;
      last_d   = 1'b1;
    end else if (cmd_i.out_ld_mem) begin
      word_d   = rdata;
      status_d = STAT_OK;
      last_d   = cmd_i.last_from_scan ? (scan_nx == back_q) : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      scan_q  <= '0;
      last_q  <= 1'b1;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      scan_q  <= scan_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    status_q <= status_d;
  end

  assign sts_o.full     = (back_up == front_q);
  assign sts_o.empty    = (back_q == front_q);
  assign sts_o.out_last = last_q;

  assign word_o   = word_q;
  assign status_o = status_q;
  assign last_o   = last_q;

endmodule

// ===== design/cdq_ctrl.sv =====
// ---------------------------------------------------------------------------
// cdq_ctrl
// Controller: decodes each item and sequences memory reads and result
// hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [OpW-1:0] op_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cdq_sts_t       sts_i,
  output cdq_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_e;

  state_e   state_q, state_d;
  logic     scan_q, scan_d;
  state_e   disp_state;
  logic     disp_scan;
  cdq_cmd_t disp_cmd;
  logic     can_accept;

  // Decode of an item in the cycle it is accepted.
  always_comb begin
    disp_cmd   = '0;
    disp_state = ST_SEND;
    disp_scan  = 1'b0;
    unique case (op_i)
      OP_PUSH_FRONT: begin
        disp_cmd.out_ld_const = 1'b1;
        if (sts_i.full) begin
          disp_cmd.out_status = STAT_FULL;
        end else begin
          disp_cmd.out_status = STAT_OK;
          disp_cmd.mem_we     = 1'b1;
          disp_cmd.addr_sel   = ADDR_FRONT_DN;
          disp_cmd.front_dn   = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        disp_cmd.out_ld_const = 1'b1;
        if (sts_i.full) begin
          disp_cmd.out_status = STAT_FULL;
        end else begin
          disp_cmd.out_status = STAT_OK;
          disp_cmd.mem_we     = 1'b1;
          disp_cmd.addr_sel   = ADDR_BACK;
          disp_cmd.back_up    = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (sts_i.empty) begin
          disp_cmd.out_ld_const  = 1'b1;
          disp_cmd.out_word_ones = 1'b1;
          disp_cmd.out_status    = STAT_EMPTY;
        end else begin
          disp_cmd.mem_re   = 1'b1;
          disp_cmd.addr_sel = ADDR_FRONT;
          disp_cmd.front_up = 1'b1;
          disp_state        = ST_READ;
        end
      end
      OP_POP_BACK: begin
        if (sts_i.empty) begin
          disp_cmd.out_ld_const  = 1'b1;
          disp_cmd.out_word_ones = 1'b1;
          disp_cmd.out_status    = STAT_EMPTY;
        end else begin
          disp_cmd.mem_re   = 1'b1;
          disp_cmd.addr_sel = ADDR_BACK_DN;
          disp_cmd.back_dn  = 1'b1;
          disp_state        = ST_READ;
        end
      end
      OP_READ_ALL: begin
        if (sts_i.empty) begin
          disp_cmd.out_ld_const = 1'b1;
          disp_cmd.out_status   = STAT_EMPTY;
        end else begin
          disp_cmd.mem_re    = 1'b1;
          disp_cmd.addr_sel  = ADDR_FRONT;
          disp_cmd.scan_load = 1'b1;
          disp_state         = ST_READ;
          disp_scan          = 1'b1;
        end
      end
      default: begin
        disp_state = ST_IDLE;
      end
    endcase
  end

  assign can_accept = (state_q == ST_IDLE) ||
                      ((state_q == ST_SEND) && out_ready_i && sts_i.out_last);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = disp_cmd;
          state_d = disp_state;
          scan_d  = disp_scan;
        end
      end
      ST_READ: begin
        cmd_o.out_ld_mem     = 1'b1;
        cmd_o.last_from_scan = scan_q;
        state_d              = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
            scan_d  = 1'b0;
            if (in_valid_i) begin
              cmd_o   = disp_cmd;
              state_d = disp_state;
              scan_d  = disp_scan;
            end
          end else begin
            cmd_o.mem_re   = 1'b1;
            cmd_o.addr_sel = ADDR_SCAN_UP;
            cmd_o.scan_up  = 1'b1;
            state_d        = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  assign in_ready_o  = can_accept;
  assign out_valid_o = (state_q == ST_SEND);

endmodule

// ===== design/circular_deque.sv =====
// ---------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring memory of DEPTH words holding up to
// DEPTH-1 entries, with push and pop at both ends and an ordered read-out.
// ---------------------------------------------------------------------------
//  Channel   | Direction | tdata            | tuser          | tlast
//  s_axis    | in        | value [31:0]     | operation[2:0] | -
//  m_axis    | out       | result_value     | status [1:0]   | last
//
// A push's result is valid in the cycle after it is accepted; a pop's result
// passes through the registered memory read and then the output register.
// A read-out loads each entry the same way and reads the next entry only after
// the previous one is taken; the single-port ring memory with its registered read sets this pace.
// A new item is taken in the cycle the final result of the previous one is.
// Reset clears the front, back and scan pointers, which leaves the queue empty; no clearing pass.
// A stalled output holds the result and the block until it is taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH = DefDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic signed [WordW-1:0] s_axis_tdata_i,   // value
  input  logic [OpW-1:0]          s_axis_tuser_i,   // operation
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic signed [WordW-1:0] m_axis_tdata_o,   // result_value
  output logic [StatW-1:0]        m_axis_tuser_o,   // status
  output logic                    m_axis_tlast_o
);

  cdq_cmd_t cmd;
  cdq_sts_t sts;

  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .op_i       (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .value_i (s_axis_tdata_i),
    .sts_o   (sts),
    .word_o  (m_axis_tdata_o),
    .status_o(m_axis_tuser_o),
    .last_o  (m_axis_tlast_o)
  );

  `CDQ_ASSERT(a_no_take_over_stalled, (s_axis_tready_o && m_axis_tvalid_o) |-> (m_axis_tready_i && m_axis_tlast_o), "Item taken while a result is stalled")
  `CDQ_ASSERT(a_full_empty_excl, !(sts.full && sts.empty), "Queue flagged full and empty at once")
  `CDQ_ASSERT(a_mem_single_access, !(cmd.mem_we && cmd.mem_re), "Ring memory read and written together")
  `CDQ_ASSERT(a_read_then_load, cmd.mem_re |=> (cmd.out_ld_mem && !m_axis_tvalid_o), "Memory read not followed by a result load")

endmodule
